// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kind codes, the result item layout and byte-class helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OffsetWidthDefault  = 32;
  localparam int KeywordSlotsDefault = 7;
  localparam int KeywordSlotsMax     = 7;
  localparam int KeywordWidth        = 64;
  localparam int CfgIndexWidth       = 3;
  localparam int QueueDepth          = 4;

  localparam logic [5:0] KIND_EOF        = 6'd0;
  localparam logic [5:0] KIND_ILLEGAL    = 6'd1;
  localparam logic [5:0] KIND_IDENT      = 6'd2;
  localparam logic [5:0] KIND_NUMBER     = 6'd3;
  localparam logic [5:0] KIND_STRING     = 6'd4;
  localparam logic [5:0] KIND_ESCSTRING  = 6'd5;
  localparam logic [5:0] KIND_OPENSTRING = 6'd6;
  localparam logic [5:0] KIND_ASSIGN     = 6'd7;
  localparam logic [5:0] KIND_EQUAL      = 6'd8;
  localparam logic [5:0] KIND_BANG       = 6'd9;
  localparam logic [5:0] KIND_NOTEQUAL   = 6'd10;
  localparam logic [5:0] KIND_PLUS       = 6'd11;
  localparam logic [5:0] KIND_MINUS      = 6'd12;
  localparam logic [5:0] KIND_STAR       = 6'd13;
  localparam logic [5:0] KIND_SLASH      = 6'd14;
  localparam logic [5:0] KIND_LESS       = 6'd15;
  localparam logic [5:0] KIND_GREATER    = 6'd16;
  localparam logic [5:0] KIND_COLON      = 6'd17;
  localparam logic [5:0] KIND_SEMI       = 6'd18;
  localparam logic [5:0] KIND_LPAREN     = 6'd19;
  localparam logic [5:0] KIND_RPAREN     = 6'd20;
  localparam logic [5:0] KIND_LBRACE     = 6'd21;
  localparam logic [5:0] KIND_RBRACE     = 6'd22;
  localparam logic [5:0] KIND_LBRACKET   = 6'd23;
  localparam logic [5:0] KIND_RBRACKET   = 6'd24;
  localparam logic [5:0] KIND_COMMA      = 6'd25;
  localparam logic [5:0] KIND_KEYWORD    = 6'd26;

  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [1:0]     results;
  } scan_out_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b == CH_UNDER) || is_letter(b) || is_digit(b);
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h2F: k = KIND_SLASH;
      8'h3C: k = KIND_LESS;
      8'h3E: k = KIND_GREATER;
      8'h3A: k = KIND_COLON;
      8'h3B: k = KIND_SEMI;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      8'h5B: k = KIND_LBRACKET;
      8'h5D: k = KIND_RBRACKET;
      8'h2C: k = KIND_COMMA;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming source text tokenizer with keyword match
// Takes one source byte per cycle (one item each clock while out_ready
// holds) and emits tokens of kind, start offset and length. A byte that
// closes a pending token and forms a token of its own gives two results,
// which leave the queue one at a time; input is taken while the four-entry
// result queue has room for two results, so items that give at most one
// result each run at one per cycle. Keywords are compared in parallel
// against the identifier buffer; results are registered in the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int OFFSET_WIDTH  = OffsetWidthDefault,
  parameter int KEYWORD_SLOTS = KeywordSlotsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [KeywordWidth-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic [7:0]               data_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [5:0]               token_code,
  output logic [31:0]              token_start,
  output logic [31:0]              token_length,
  output logic                     last_of_run
);

  logic [KeywordWidth-1:0] keyword [KEYWORD_SLOTS];
  logic                    accept;
  scan_out_t               scan_out;
  result_t                 head;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) begin
        keyword[i] <= '0;
      end
    end else if (cfg_write) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) begin
        if (cfg_index == CfgIndexWidth'(i)) begin
          keyword[i] <= cfg_data;
        end
      end
    end
  end

  assign accept = in_valid && in_ready;

  stt_scan #(
    .OFFSET_WIDTH  (OFFSET_WIDTH),
    .KEYWORD_SLOTS (KEYWORD_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (func),
    .data_byte (data_byte),
    .keyword   (keyword),
    .scan_out  (scan_out)
  );

  stt_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (scan_out),
    .pop        (out_ready),
    .room       (in_ready),
    .head_valid (out_valid),
    .head       (head)
  );

  assign token_code   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

// ===== hw/rtl/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan: scanner state and token decision
// Holds the scan state and turns one accepted item into up to two results.
// ----------------------------------------------------------------------------
module stt_scan
  import stt_pkg::*;
#(
  parameter int OFFSET_WIDTH  = OffsetWidthDefault,
  parameter int KEYWORD_SLOTS = KeywordSlotsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    func,
  input  logic [7:0]              data_byte,
  input  logic [KeywordWidth-1:0] keyword [KEYWORD_SLOTS],
  output scan_out_t               scan_out
);

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_IDENT  = 7'b0000010,
    M_NUMBER = 7'b0000100,
    M_STRING = 7'b0001000,
    M_STRBS  = 7'b0010000,
    M_EQ     = 7'b0100000,
    M_BANG   = 7'b1000000
  } mode_t;

  localparam logic [OFFSET_WIDTH-1:0] OfsOne   = OFFSET_WIDTH'(1);
  localparam logic [OFFSET_WIDTH-1:0] OfsTwo   = OFFSET_WIDTH'(2);
  localparam logic [OFFSET_WIDTH-1:0] OfsEight = OFFSET_WIDTH'(8);

  mode_t                   mode, mode_next;
  logic [OFFSET_WIDTH-1:0] offset, offset_next;
  logic [OFFSET_WIDTH-1:0] pstart, pstart_next;
  logic [OFFSET_WIDTH-1:0] plen, plen_next;
  logic [KeywordWidth-1:0] word, word_next;
  logic                    too_long, too_long_next;
  logic                    escaped, escaped_next;

  function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] x);
    return (&x) ? x : x + OfsOne;
  endfunction

  function automatic logic [31:0] to32(input logic [OFFSET_WIDTH-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  logic [5:0] word_kind;

  always_comb begin
    word_kind = KIND_IDENT;
    if (!too_long) begin
      for (int i = 0; i < KEYWORD_SLOTS; i++) begin
        if ((keyword[i] != '0) && (keyword[i] == word)) begin
          word_kind = KIND_KEYWORD + 6'(i);
        end
      end
    end
  end

  result_t [1:0]           res;
  logic [1:0]              cnt;
  logic                    start_tok;
  logic                    str_byte;
  logic                    do_flush;
  logic [5:0]              fl_kind;
  logic [OFFSET_WIDTH-1:0] fl_len;
  logic                    fl_hit;
  logic [OFFSET_WIDTH-1:0] plen_inc;

  always_comb begin
    fl_hit  = 1'b1;
    fl_kind = KIND_IDENT;
    fl_len  = plen;
    case (mode)
      M_IDENT:  fl_kind = word_kind;
      M_NUMBER: fl_kind = KIND_NUMBER;
      M_STRING: fl_kind = KIND_OPENSTRING;
      M_STRBS:  fl_kind = KIND_OPENSTRING;
      M_EQ: begin
        fl_kind = KIND_ASSIGN;
        fl_len  = OfsOne;
      end
      M_BANG: begin
        fl_kind = KIND_BANG;
        fl_len  = OfsOne;
      end
      default: fl_hit = 1'b0;
    endcase
  end

  always_comb begin
    mode_next     = mode;
    offset_next   = offset;
    pstart_next   = pstart;
    plen_next     = plen;
    word_next     = word;
    too_long_next = too_long;
    escaped_next  = escaped;
    res           = '0;
    cnt           = 2'd0;
    start_tok     = 1'b0;
    str_byte      = 1'b0;
    do_flush      = 1'b0;
    plen_inc      = sat_inc(plen);

    if (func) begin
      if (fl_hit) begin
        res[0] = '{kind: fl_kind, start: to32(pstart), length: to32(fl_len), last: 1'b0};
        cnt    = 2'd1;
      end
      res[cnt[0]] = '{kind: KIND_EOF, start: to32(offset), length: 32'd0, last: 1'b0};
      cnt         = cnt + 2'd1;
      mode_next   = M_IDLE;
      offset_next = '0;
    end else begin
      offset_next = sat_inc(offset);
      case (mode)
        M_IDENT: begin
          if (is_word(data_byte)) begin
            if (plen < OfsEight) begin
              for (int i = 0; i < 8; i++) begin
                if (plen[2:0] == 3'(i)) begin
                  word_next[8*i +: 8] = word[8*i +: 8] | data_byte;
                end
              end
            end else begin
              too_long_next = 1'b1;
            end
            plen_next = plen_inc;
          end else begin
            do_flush  = 1'b1;
            start_tok = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(data_byte)) begin
            plen_next = plen_inc;
          end else begin
            do_flush  = 1'b1;
            start_tok = 1'b1;
          end
        end
        M_STRING: str_byte = 1'b1;
        M_STRBS: begin
          if ((data_byte == CH_BSLASH) || (data_byte == CH_QUOTE) ||
              (data_byte == CH_T) || (data_byte == CH_N)) begin
            plen_next    = plen_inc;
            escaped_next = 1'b1;
            mode_next    = M_STRING;
          end else begin
            str_byte = 1'b1;
          end
        end
        M_EQ, M_BANG: begin
          if (data_byte == CH_EQUAL) begin
            res[0] = '{kind: (mode == M_EQ) ? KIND_EQUAL : KIND_NOTEQUAL,
                       start: to32(pstart), length: to32(OfsTwo), last: 1'b0};
            cnt       = 2'd1;
            mode_next = M_IDLE;
          end else begin
            do_flush  = 1'b1;
            start_tok = 1'b1;
          end
        end
        default: start_tok = 1'b1;
      endcase

      if (do_flush && fl_hit) begin
        res[0] = '{kind: fl_kind, start: to32(pstart), length: to32(fl_len), last: 1'b0};
        cnt    = 2'd1;
      end

      if (str_byte) begin
        plen_next = plen_inc;
        if (data_byte == CH_QUOTE) begin
          res[0] = '{kind: escaped ? KIND_ESCSTRING : KIND_STRING,
                     start: to32(pstart), length: to32(plen_inc), last: 1'b0};
          cnt       = 2'd1;
          mode_next = M_IDLE;
        end else if (data_byte == CH_BSLASH) begin
          mode_next = M_STRBS;
        end else begin
          mode_next = M_STRING;
        end
      end

      if (start_tok) begin
        mode_next   = M_IDLE;
        pstart_next = offset;
        plen_next   = OfsOne;
        if (is_space(data_byte)) begin
          mode_next = M_IDLE;
        end else if (data_byte == CH_EQUAL) begin
          mode_next = M_EQ;
        end else if (data_byte == CH_BANG) begin
          mode_next = M_BANG;
        end else if (data_byte == CH_QUOTE) begin
          mode_next    = M_STRING;
          escaped_next = 1'b0;
        end else if (is_digit(data_byte)) begin
          mode_next = M_NUMBER;
        end else if (is_word(data_byte)) begin
          mode_next     = M_IDENT;
          word_next     = KeywordWidth'(data_byte);
          too_long_next = 1'b0;
        end else begin
          res[cnt[0]] = '{kind: punct_kind(data_byte), start: to32(offset),
                          length: 32'd1, last: 1'b0};
          cnt         = cnt + 2'd1;
        end
      end
    end

    if (cnt == 2'd1) begin
      res[0].last = 1'b1;
    end else if (cnt == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign scan_out.count   = cnt;
  assign scan_out.results = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      offset   <= '0;
      pstart   <= '0;
      plen     <= '0;
      word     <= '0;
      too_long <= 1'b0;
      escaped  <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      offset   <= offset_next;
      pstart   <= pstart_next;
      plen     <= plen_next;
      word     <= word_next;
      too_long <= too_long_next;
      escaped  <= escaped_next;
    end
  end

`ifndef SYNTHESIS
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    accept && func |=> (mode == M_IDLE) && (offset == '0))
    else $error("end of input did not clear scan state");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    accept && func |-> (cnt != 2'd0) && (res[cnt[0] ^ 1'b1].kind == KIND_EOF))
    else $error("end of input did not end with eof token");
`endif

endmodule

// ===== hw/rtl/stt_result_queue.sv =====
// ----------------------------------------------------------------------------
// stt_result_queue: result item queue
// Takes up to two result items per cycle and hands out one per cycle while pop is held.
// ----------------------------------------------------------------------------
module stt_result_queue
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scan_out_t push_data,
  input  logic      pop,
  output logic      room,
  output logic      head_valid,
  output result_t   head
);

  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam int CountWidth = $clog2(QueueDepth + 1);
  localparam logic [CountWidth-1:0] RoomLimit = CountWidth'(QueueDepth - 2);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(QueueDepth);

  result_t               mem [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CountWidth-1:0] count, count_next;
  logic [1:0]            push_n;
  logic                  do_pop;

  assign push_n     = push ? push_data.count : 2'd0;
  assign do_pop     = pop && (count != '0);
  assign room       = (count <= RoomLimit);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign count_next = count + CountWidth'(push_n) - CountWidth'(do_pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_data.results[0];
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PtrWidth'(1)] <= push_data.results[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrWidth'(push_n);
      rd_ptr <= rd_ptr + PtrWidth'(do_pop);
      count  <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FullCount)
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("item taken without room for its results");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd0) && !do_pop |=> $stable(count))
    else $error("queue count moved without push or pop");
`endif

endmodule
